FILE: design/tcc_pkg.sv
// Shared widths, types and helpers for the triangle circumcircle pipeline.
// No dependencies; all design files but tcc_chk refer to it by scoped names.
`default_nettype none

package tcc_pkg;

    // Input coordinate width and fraction bits of the center.
    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 8;

    // Derived widths
    localparam int DW    = COORD_BITS + 1;       // coordinate difference
    localparam int LW    = 2 * DW;               // squared length
    localparam int DETW  = 2 * DW + 1;           // orientation determinant
    localparam int NW    = DW + LW + 1;          // bisector numerator
    localparam int NUMW  = NW + FRAC_BITS + 1;   // scaled dividend
    localparam int DVW   = DETW + 1;             // divisor, 4 * |det|
    localparam int QW    = 40;                   // quotient bits before clipping
    localparam int PW    = QW + 3;               // center before clipping
    localparam int OUTW  = 32;                   // center output
    localparam int RADW  = 63;                   // squared radius output
    localparam int SQIN  = 32;                   // offset bits that may be squared
    localparam int RSH   = (FRAC_BITS == 0) ? 0 : 2 * FRAC_BITS - 1;

    // Pipeline latencies
    localparam int LAT_FRONT = 3;
    localparam int LAT_SETUP = 5;
    localparam int DIV_LAT   = QW + 1;
    localparam int LAT_BACK  = 2;
    localparam int LAT_TOTAL = LAT_FRONT + LAT_SETUP + DIV_LAT + LAT_BACK;

    localparam logic [RADW-1:0] RAD_MAX = {RADW{1'b1}};
    localparam logic signed [PW-1:0] OUT_MAX = {{(PW-OUTW+1){1'b0}}, {(OUTW-1){1'b1}}};
    localparam logic signed [PW-1:0] OUT_MIN = {{(PW-OUTW+1){1'b1}}, {(OUTW-1){1'b0}}};

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DW-1:0]         t_diff;
    typedef logic [LW-1:0]                t_len;
    typedef logic signed [DETW-1:0]       t_det;
    typedef logic signed [OUTW-1:0]       t_out;

    // Front end result: corners, differences, determinant, squared lengths
    typedef struct packed {
        t_coord ax;
        t_coord ay;
        t_coord bx;
        t_coord by_c;
        t_coord cx;
        t_coord cy;
        t_diff  d1x;   // B - A
        t_diff  d1y;
        t_diff  d2x;   // C - A
        t_diff  d2y;
        t_diff  d3x;   // C - B
        t_diff  d3y;
        t_det   det;
        t_len   lab;
        t_len   lac;
        t_len   lbc;
    } t_front;

    // Per-item data that bypasses the dividers
    typedef struct packed {
        logic            neg_x;
        logic            neg_y;
        t_coord          base_x;
        t_coord          base_y;
        logic            swp;
        logic            col;
        t_out            col_x;
        t_out            col_y;
        logic [RADW-1:0] col_rad;
        logic            col_sat;
    } t_side;

    typedef struct packed {
        logic sat;
        t_out val;
    } t_clip;

    // Clip a wide center value into the output range
    function automatic t_clip clip_out(input logic signed [PW-1:0] v);
        t_clip r;
        begin
            if (v > OUT_MAX) begin
                r.sat = 1'b1;
                r.val = OUT_MAX[OUTW-1:0];
            end else if (v < OUT_MIN) begin
                r.sat = 1'b1;
                r.val = OUT_MIN[OUTW-1:0];
            end else begin
                r.sat = 1'b0;
                r.val = v[OUTW-1:0];
            end
            return r;
        end
    endfunction

endpackage

`default_nettype wire

FILE: design/tcc_front.sv
// Front end: differences, cross products and squares, determinant and lengths.
// Three register stages; uses tcc_pkg.
`default_nettype none

module tcc_front (
    input  logic            i_clk,
    input  logic            i_en,
    input  tcc_pkg::t_coord i_ax,
    input  tcc_pkg::t_coord i_ay,
    input  tcc_pkg::t_coord i_bx,
    input  tcc_pkg::t_coord i_by_coord,
    input  tcc_pkg::t_coord i_cx,
    input  tcc_pkg::t_coord i_cy,
    output tcc_pkg::t_front o_front
);

    tcc_pkg::t_coord r1_ax, r1_ay, r1_bx, r1_by, r1_cx, r1_cy;
    tcc_pkg::t_diff  r1_d1x, r1_d1y, r1_d2x, r1_d2y, r1_d3x, r1_d3y;

    tcc_pkg::t_coord r2_ax, r2_ay, r2_bx, r2_by, r2_cx, r2_cy;
    tcc_pkg::t_diff  r2_d1x, r2_d1y, r2_d2x, r2_d2y, r2_d3x, r2_d3y;
    logic signed [tcc_pkg::LW-1:0] r2_p1, r2_p2;
    logic signed [tcc_pkg::LW-1:0] r2_s1x, r2_s1y, r2_s2x, r2_s2y, r2_s3x, r2_s3y;

    tcc_pkg::t_front r3_front;

    // Stage 1: edge vectors
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax  <= i_ax;
            r1_ay  <= i_ay;
            r1_bx  <= i_bx;
            r1_by  <= i_by_coord;
            r1_cx  <= i_cx;
            r1_cy  <= i_cy;
            r1_d1x <= tcc_pkg::DW'(i_bx) - tcc_pkg::DW'(i_ax);
            r1_d1y <= tcc_pkg::DW'(i_by_coord) - tcc_pkg::DW'(i_ay);
            r1_d2x <= tcc_pkg::DW'(i_cx) - tcc_pkg::DW'(i_ax);
            r1_d2y <= tcc_pkg::DW'(i_cy) - tcc_pkg::DW'(i_ay);
            r1_d3x <= tcc_pkg::DW'(i_cx) - tcc_pkg::DW'(i_bx);
            r1_d3y <= tcc_pkg::DW'(i_cy) - tcc_pkg::DW'(i_by_coord);
        end
    end

    // Stage 2: cross products and squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_ax  <= r1_ax;
            r2_ay  <= r1_ay;
            r2_bx  <= r1_bx;
            r2_by  <= r1_by;
            r2_cx  <= r1_cx;
            r2_cy  <= r1_cy;
            r2_d1x <= r1_d1x;
            r2_d1y <= r1_d1y;
            r2_d2x <= r1_d2x;
            r2_d2y <= r1_d2y;
            r2_d3x <= r1_d3x;
            r2_d3y <= r1_d3y;
            r2_p1  <= r1_d1x * r1_d2y;
            r2_p2  <= r1_d2x * r1_d1y;
            r2_s1x <= r1_d1x * r1_d1x;
            r2_s1y <= r1_d1y * r1_d1y;
            r2_s2x <= r1_d2x * r1_d2x;
            r2_s2y <= r1_d2y * r1_d2y;
            r2_s3x <= r1_d3x * r1_d3x;
            r2_s3y <= r1_d3y * r1_d3y;
        end
    end

    // Stage 3: determinant and squared edge lengths
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_front.ax   <= r2_ax;
            r3_front.ay   <= r2_ay;
            r3_front.bx   <= r2_bx;
            r3_front.by_c <= r2_by;
            r3_front.cx   <= r2_cx;
            r3_front.cy   <= r2_cy;
            r3_front.d1x  <= r2_d1x;
            r3_front.d1y  <= r2_d1y;
            r3_front.d2x  <= r2_d2x;
            r3_front.d2y  <= r2_d2y;
            r3_front.d3x  <= r2_d3x;
            r3_front.d3y  <= r2_d3y;
            r3_front.det  <= tcc_pkg::DETW'(r2_p1) - tcc_pkg::DETW'(r2_p2);
            r3_front.lab  <= tcc_pkg::t_len'(r2_s1x) + tcc_pkg::t_len'(r2_s1y);
            r3_front.lac  <= tcc_pkg::t_len'(r2_s2x) + tcc_pkg::t_len'(r2_s2y);
            r3_front.lbc  <= tcc_pkg::t_len'(r2_s3x) + tcc_pkg::t_len'(r2_s3y);
        end
    end

    assign o_front = r3_front;

endmodule

`default_nettype wire

FILE: design/tcc_setup.sv
// Setup: orientation fix, collinear fallback circle and divider operands.
// Five register stages; uses tcc_pkg.
`default_nettype none

module tcc_setup (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  tcc_pkg::t_front             i_front,
    output logic [tcc_pkg::NUMW-1:0]    o_num_x,
    output logic [tcc_pkg::NUMW-1:0]    o_num_y,
    output logic [tcc_pkg::DVW-1:0]     o_dv,
    output tcc_pkg::t_side              o_side
);

    // Round half away from zero of t / 2
    function automatic logic signed [tcc_pkg::PW-1:0] half_away(
        input logic signed [tcc_pkg::PW-1:0] t);
        logic signed [tcc_pkg::PW-1:0] m;
        begin
            m = t[tcc_pkg::PW-1] ? -t : t;
            m = (m + tcc_pkg::PW'(1)) >>> 1;
            return t[tcc_pkg::PW-1] ? -m : m;
        end
    endfunction

    logic                         n_neg;
    tcc_pkg::t_coord              n_px, n_py, n_qx, n_qy;
    tcc_pkg::t_len                n_best;
    tcc_pkg::t_det                n_adet;

    // stage 4
    tcc_pkg::t_diff               r4_ux, r4_uy, r4_vx, r4_vy;
    tcc_pkg::t_len                r4_lu, r4_lv;
    logic [tcc_pkg::DETW-2:0]     r4_adet;
    tcc_pkg::t_diff               r4_sx, r4_sy;
    tcc_pkg::t_len                r4_best;
    tcc_pkg::t_side               r4_side;

    // stage 5
    logic signed [tcc_pkg::NW-1:0] r5_m1, r5_m2, r5_m3, r5_m4;
    logic [tcc_pkg::DETW-2:0]      r5_adet;
    tcc_pkg::t_side                r5_side;
    tcc_pkg::t_clip                n_cx, n_cy;
    logic [tcc_pkg::RADW-1:0]      n_rad;
    logic                          n_rsat;
    tcc_pkg::t_side                n_side5;

    // stage 6
    logic signed [tcc_pkg::NW-1:0] r6_nx, r6_ny;
    logic [tcc_pkg::DETW-2:0]      r6_adet;
    tcc_pkg::t_side                r6_side;

    // stage 7
    logic [tcc_pkg::NW-2:0]        r7_mx, r7_my;
    logic [tcc_pkg::DETW-2:0]      r7_adet;
    tcc_pkg::t_side                r7_side;
    logic signed [tcc_pkg::NW-1:0] n_ax, n_ay;
    tcc_pkg::t_side                n_side7;

    // stage 8
    logic [tcc_pkg::NUMW-1:0]      r8_num_x, r8_num_y;
    logic [tcc_pkg::DVW-1:0]       r8_dv;
    tcc_pkg::t_side                r8_side;

    // Longest pair for the collinear case; later pair wins a tie
    always_comb begin
        n_neg  = i_front.det[tcc_pkg::DETW-1];
        n_adet = n_neg ? -i_front.det : i_front.det;
        n_px   = i_front.ax;
        n_py   = i_front.ay;
        n_qx   = i_front.bx;
        n_qy   = i_front.by_c;
        n_best = i_front.lab;
        if (i_front.lac >= n_best) begin
            n_best = i_front.lac;
            n_qx   = i_front.cx;
            n_qy   = i_front.cy;
        end
        if (i_front.lbc >= n_best) begin
            n_best = i_front.lbc;
            n_px   = i_front.bx;
            n_py   = i_front.by_c;
            n_qx   = i_front.cx;
            n_qy   = i_front.cy;
        end
    end

    // Stage 4: swap A and C for a clockwise triangle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_ux   <= n_neg ? -i_front.d3x : i_front.d1x;
            r4_uy   <= n_neg ? -i_front.d3y : i_front.d1y;
            r4_vx   <= n_neg ? -i_front.d2x : i_front.d2x;
            r4_vy   <= n_neg ? -i_front.d2y : i_front.d2y;
            r4_lu   <= n_neg ? i_front.lbc : i_front.lab;
            r4_lv   <= i_front.lac;
            r4_adet <= n_adet[tcc_pkg::DETW-2:0];
            r4_sx   <= tcc_pkg::DW'(n_px) + tcc_pkg::DW'(n_qx);
            r4_sy   <= tcc_pkg::DW'(n_py) + tcc_pkg::DW'(n_qy);
            r4_best <= n_best;
            r4_side.neg_x   <= 1'b0;
            r4_side.neg_y   <= 1'b0;
            r4_side.base_x  <= n_neg ? i_front.cx : i_front.ax;
            r4_side.base_y  <= n_neg ? i_front.cy : i_front.ay;
            r4_side.swp     <= n_neg;
            r4_side.col     <= (i_front.det == '0);
            r4_side.col_x   <= '0;
            r4_side.col_y   <= '0;
            r4_side.col_rad <= '0;
            r4_side.col_sat <= 1'b0;
        end
    end

    // Fallback circle: rounded midpoint and half squared length
    always_comb begin
        n_cx = tcc_pkg::clip_out(half_away(tcc_pkg::PW'(r4_sx) <<< tcc_pkg::FRAC_BITS));
        n_cy = tcc_pkg::clip_out(half_away(tcc_pkg::PW'(r4_sy) <<< tcc_pkg::FRAC_BITS));
        n_rsat = 1'b0;
        if (tcc_pkg::FRAC_BITS == 0) begin
            n_rad = (tcc_pkg::RADW'(r4_best) + tcc_pkg::RADW'(1)) >> 1;
        end else if (tcc_pkg::RADW'(r4_best) > (tcc_pkg::RAD_MAX >> tcc_pkg::RSH)) begin
            n_rad  = tcc_pkg::RAD_MAX;
            n_rsat = 1'b1;
        end else begin
            n_rad = tcc_pkg::RADW'(r4_best) << tcc_pkg::RSH;
        end
        n_side5         = r4_side;
        n_side5.col_x   = n_cx.val;
        n_side5.col_y   = n_cy.val;
        n_side5.col_rad = n_rad;
        n_side5.col_sat = n_cx.sat | n_cy.sat | n_rsat;
    end

    // Stage 5: numerator products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_m1   <= r4_vy * $signed({1'b0, r4_lu});
            r5_m2   <= r4_uy * $signed({1'b0, r4_lv});
            r5_m3   <= r4_ux * $signed({1'b0, r4_lv});
            r5_m4   <= r4_vx * $signed({1'b0, r4_lu});
            r5_adet <= r4_adet;
            r5_side <= n_side5;
        end
    end

    // Stage 6: bisector numerators
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r6_nx   <= r5_m1 - r5_m2;
            r6_ny   <= r5_m3 - r5_m4;
            r6_adet <= r5_adet;
            r6_side <= r5_side;
        end
    end

    // Stage 7: sign and magnitude
    always_comb begin
        n_ax = r6_nx[tcc_pkg::NW-1] ? -r6_nx : r6_nx;
        n_ay = r6_ny[tcc_pkg::NW-1] ? -r6_ny : r6_ny;
        n_side7       = r6_side;
        n_side7.neg_x = r6_nx[tcc_pkg::NW-1];
        n_side7.neg_y = r6_ny[tcc_pkg::NW-1];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r7_mx   <= n_ax[tcc_pkg::NW-2:0];
            r7_my   <= n_ay[tcc_pkg::NW-2:0];
            r7_adet <= r6_adet;
            r7_side <= n_side7;
        end
    end

    // Stage 8: scaled dividend with rounding bias, divisor 4 * |det|
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r8_num_x <= tcc_pkg::NUMW'({r7_mx, {(tcc_pkg::FRAC_BITS+1){1'b0}}})
                      + tcc_pkg::NUMW'({r7_adet, 1'b0});
            r8_num_y <= tcc_pkg::NUMW'({r7_my, {(tcc_pkg::FRAC_BITS+1){1'b0}}})
                      + tcc_pkg::NUMW'({r7_adet, 1'b0});
            r8_dv    <= {r7_adet, 2'b00};
            r8_side  <= r7_side;
        end
    end

    assign o_num_x = r8_num_x;
    assign o_num_y = r8_num_y;
    assign o_dv    = r8_dv;
    assign o_side  = r8_side;

endmodule

`default_nettype wire

FILE: design/tcc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow check.
// Uses tcc_pkg.
`default_nettype none

module tcc_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [tcc_pkg::NUMW-1:0]  i_num,
    input  logic [tcc_pkg::DVW-1:0]   i_dv,
    output logic [tcc_pkg::QW-1:0]    o_q,
    output logic                      o_ovf
);

    logic [tcc_pkg::DVW-1:0] r_rem [0:tcc_pkg::QW-1];
    logic [tcc_pkg::QW-1:0]  r_lo  [0:tcc_pkg::QW-1];
    logic [tcc_pkg::QW-1:0]  r_q   [0:tcc_pkg::QW];
    logic [tcc_pkg::DVW-1:0] r_dv  [0:tcc_pkg::QW-1];
    logic                    r_ovf [0:tcc_pkg::QW];

    logic [tcc_pkg::DVW:0]   n_rem2 [1:tcc_pkg::QW];
    logic                    n_ge   [1:tcc_pkg::QW];

    // One compare per stage
    always_comb begin
        for (int k = 1; k <= tcc_pkg::QW; k++) begin
            n_rem2[k] = {r_rem[k-1], r_lo[k-1][tcc_pkg::QW-1]};
            n_ge[k]   = n_rem2[k] >= {1'b0, r_dv[k-1]};
        end
    end

    // Entry stage flags a quotient that would not fit in QW bits, then one
    // conditional subtract per stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= tcc_pkg::DVW'(i_num[tcc_pkg::NUMW-1:tcc_pkg::QW]);
            r_lo[0]  <= i_num[tcc_pkg::QW-1:0];
            r_q[0]   <= '0;
            r_dv[0]  <= i_dv;
            r_ovf[0] <= tcc_pkg::DVW'(i_num[tcc_pkg::NUMW-1:tcc_pkg::QW]) >= i_dv;
            for (int k = 1; k < tcc_pkg::QW; k++) begin
                r_rem[k] <= n_ge[k] ? tcc_pkg::DVW'(n_rem2[k] - {1'b0, r_dv[k-1]})
                                    : n_rem2[k][tcc_pkg::DVW-1:0];
                r_lo[k]  <= {r_lo[k-1][tcc_pkg::QW-2:0], 1'b0};
                r_dv[k]  <= r_dv[k-1];
            end
            for (int k = 1; k <= tcc_pkg::QW; k++) begin
                r_q[k]   <= {r_q[k-1][tcc_pkg::QW-2:0], n_ge[k]};
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign o_q   = r_q[tcc_pkg::QW];
    assign o_ovf = r_ovf[tcc_pkg::QW];

endmodule

`default_nettype wire

FILE: design/tcc_back.sv
// Back end: center placement and clipping, squared radius, result select.
// Two register stages, the second is the output register; uses tcc_pkg.
`default_nettype none

module tcc_back (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [tcc_pkg::QW-1:0]    i_q_x,
    input  logic [tcc_pkg::QW-1:0]    i_q_y,
    input  logic                      i_ovf_x,
    input  logic                      i_ovf_y,
    input  tcc_pkg::t_side            i_side,
    output tcc_pkg::t_out             o_center_x,
    output tcc_pkg::t_out             o_center_y,
    output logic [tcc_pkg::RADW-1:0]  o_square_radius,
    output logic                      o_swapped,
    output logic                      o_collinear,
    output logic                      o_saturated
);

    logic signed [tcc_pkg::PW-1:0] n_vx, n_vy;
    tcc_pkg::t_clip                n_clx, n_cly;

    tcc_pkg::t_out                 r1_cx, r1_cy;
    logic                          r1_csat, r1_big;
    logic [2*tcc_pkg::SQIN-1:0]    r1_sx, r1_sy;
    tcc_pkg::t_side                r1_side;

    logic [2*tcc_pkg::SQIN:0]      n_sum;
    logic                          n_rsat;

    tcc_pkg::t_out                 r2_cx, r2_cy;
    logic [tcc_pkg::RADW-1:0]      r2_rad;
    logic                          r2_swp, r2_col, r2_sat;

    // Center = corner plus signed offset, clipped
    always_comb begin
        n_vx = tcc_pkg::PW'(i_side.base_x) <<< tcc_pkg::FRAC_BITS;
        n_vy = tcc_pkg::PW'(i_side.base_y) <<< tcc_pkg::FRAC_BITS;
        n_vx = i_side.neg_x ? n_vx - $signed(tcc_pkg::PW'(i_q_x))
                            : n_vx + $signed(tcc_pkg::PW'(i_q_x));
        n_vy = i_side.neg_y ? n_vy - $signed(tcc_pkg::PW'(i_q_y))
                            : n_vy + $signed(tcc_pkg::PW'(i_q_y));
        n_clx = tcc_pkg::clip_out(n_vx);
        n_cly = tcc_pkg::clip_out(n_vy);
        if (i_ovf_x) begin
            n_clx.sat = 1'b1;
            n_clx.val = i_side.neg_x ? tcc_pkg::OUT_MIN[tcc_pkg::OUTW-1:0]
                                     : tcc_pkg::OUT_MAX[tcc_pkg::OUTW-1:0];
        end
        if (i_ovf_y) begin
            n_cly.sat = 1'b1;
            n_cly.val = i_side.neg_y ? tcc_pkg::OUT_MIN[tcc_pkg::OUTW-1:0]
                                     : tcc_pkg::OUT_MAX[tcc_pkg::OUTW-1:0];
        end
    end

    // Stage 1: center and squared offsets
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_cx   <= n_clx.val;
            r1_cy   <= n_cly.val;
            r1_csat <= n_clx.sat | n_cly.sat;
            r1_big  <= i_ovf_x | i_ovf_y
                     | (i_q_x[tcc_pkg::QW-1:tcc_pkg::SQIN] != '0)
                     | (i_q_y[tcc_pkg::QW-1:tcc_pkg::SQIN] != '0);
            r1_sx   <= i_q_x[tcc_pkg::SQIN-1:0] * i_q_x[tcc_pkg::SQIN-1:0];
            r1_sy   <= i_q_y[tcc_pkg::SQIN-1:0] * i_q_y[tcc_pkg::SQIN-1:0];
            r1_side <= i_side;
        end
    end

    // Radius sum with clipping
    always_comb begin
        n_sum  = {1'b0, r1_sx} + {1'b0, r1_sy};
        n_rsat = r1_big | (n_sum[2*tcc_pkg::SQIN:tcc_pkg::RADW] != '0);
    end

    // Stage 2: output register, fallback circle for collinear items
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_swp <= r1_side.swp;
            r2_col <= r1_side.col;
            if (r1_side.col) begin
                r2_cx  <= r1_side.col_x;
                r2_cy  <= r1_side.col_y;
                r2_rad <= r1_side.col_rad;
                r2_sat <= r1_side.col_sat;
            end else begin
                r2_cx  <= r1_cx;
                r2_cy  <= r1_cy;
                r2_rad <= n_rsat ? tcc_pkg::RAD_MAX : n_sum[tcc_pkg::RADW-1:0];
                r2_sat <= r1_csat | n_rsat;
            end
        end
    end

    assign o_center_x      = r2_cx;
    assign o_center_y      = r2_cy;
    assign o_square_radius = r2_rad;
    assign o_swapped       = r2_swp;
    assign o_collinear     = r2_col;
    assign o_saturated     = r2_sat;

endmodule

`default_nettype wire

FILE: design/triangle_circumcircle.sv
// Triangle circumcircle top level: front end, setup, two dividers, back end.
// Uses tcc_pkg, tcc_front, tcc_setup, tcc_div and tcc_back.
//
// Input channel: i_valid / o_stall with the three corners, one triangle per item.
// Output channel: o_valid / i_stall with center, squared radius and flags.
// An item is taken at a clock edge where valid is high and stall is low.
// Pipeline stages in order: 3 front end, 5 setup, 41 divider stages (an entry
// stage, then one quotient bit each), 2 back end.
// One item per cycle unless stalled; both dividers are fully pipelined.
// The whole pipeline moves on one enable; when a result sits in the output
// register and i_stall is high, every stage holds and o_stall is raised, so no
// item is dropped or repeated. Empty slots hold too while the result waits.
// Reset (synchronous, active low) clears the valid bits only; the block has no
// other state and no configuration.
`default_nettype none

module triangle_circumcircle (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic signed [15:0]               i_ax,
    input  logic signed [15:0]               i_ay,
    input  logic signed [15:0]               i_bx,
    input  logic signed [15:0]               i_by_coord,
    input  logic signed [15:0]               i_cx,
    input  logic signed [15:0]               i_cy,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [31:0]               o_center_x,
    output logic signed [31:0]               o_center_y,
    output logic [62:0]                      o_square_radius,
    output logic                             o_swapped,
    output logic                             o_collinear,
    output logic                             o_saturated
);

    logic                           n_en;
    logic [tcc_pkg::LAT_TOTAL-1:0]  r_vld;

    tcc_pkg::t_front                w_front;
    logic [tcc_pkg::NUMW-1:0]       w_num_x, w_num_y;
    logic [tcc_pkg::DVW-1:0]        w_dv;
    tcc_pkg::t_side                 w_side;
    tcc_pkg::t_side                 r_side_dl [0:tcc_pkg::DIV_LAT-1];
    logic [tcc_pkg::QW-1:0]         w_q_x, w_q_y;
    logic                           w_ovf_x, w_ovf_y;

    // Global advance: hold everything while the output is stalled
    assign n_en    = !(r_vld[tcc_pkg::LAT_TOTAL-1] && i_stall);
    assign o_stall = !n_en;
    assign o_valid = r_vld[tcc_pkg::LAT_TOTAL-1];

    // Valid bits travel alongside the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[tcc_pkg::LAT_TOTAL-2:0], i_valid};
        end
    end

    tcc_front u_front (
        .i_clk      (i_clk),
        .i_en       (n_en),
        .i_ax       (i_ax),
        .i_ay       (i_ay),
        .i_bx       (i_bx),
        .i_by_coord (i_by_coord),
        .i_cx       (i_cx),
        .i_cy       (i_cy),
        .o_front    (w_front)
    );

    tcc_setup u_setup (
        .i_clk   (i_clk),
        .i_en    (n_en),
        .i_front (w_front),
        .o_num_x (w_num_x),
        .o_num_y (w_num_y),
        .o_dv    (w_dv),
        .o_side  (w_side)
    );

    tcc_div u_div_x (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (w_num_x),
        .i_dv  (w_dv),
        .o_q   (w_q_x),
        .o_ovf (w_ovf_x)
    );

    tcc_div u_div_y (
        .i_clk (i_clk),
        .i_en  (n_en),
        .i_num (w_num_y),
        .i_dv  (w_dv),
        .o_q   (w_q_y),
        .o_ovf (w_ovf_y)
    );

    // Side data delayed to match the dividers
    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_side_dl[0] <= w_side;
            for (int k = 1; k < tcc_pkg::DIV_LAT; k++) begin
                r_side_dl[k] <= r_side_dl[k-1];
            end
        end
    end

    tcc_back u_back (
        .i_clk           (i_clk),
        .i_en            (n_en),
        .i_q_x           (w_q_x),
        .i_q_y           (w_q_y),
        .i_ovf_x         (w_ovf_x),
        .i_ovf_y         (w_ovf_y),
        .i_side          (r_side_dl[tcc_pkg::DIV_LAT-1]),
        .o_center_x      (o_center_x),
        .o_center_y      (o_center_y),
        .o_square_radius (o_square_radius),
        .o_swapped       (o_swapped),
        .o_collinear     (o_collinear),
        .o_saturated     (o_saturated)
    );

endmodule

`default_nettype wire

FILE: design/tcc_chk.sv
// Port-level checker for triangle_circumcircle, attached by bind.
// No dependencies beyond the top level's ports.
`default_nettype none

module tcc_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_stall,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_center_x,
    input  logic signed [31:0] o_center_y,
    input  logic [62:0]        o_square_radius,
    input  logic               o_swapped,
    input  logic               o_collinear,
    input  logic               o_saturated
);

    // A stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_center_x) && $stable(o_center_y)
                                  && $stable(o_square_radius) && $stable(o_swapped)
                                  && $stable(o_collinear) && $stable(o_saturated)))
        else $error("stalled result changed");

    // The input is held off exactly when a finished item waits
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output stall");

    // Collinear items are never reordered
    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_collinear) |-> !o_swapped)
        else $error("collinear item flagged as swapped");

    // Reset empties the pipeline
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid result right after reset");

endmodule

bind triangle_circumcircle tcc_chk u_tcc_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_center_x      (o_center_x),
    .o_center_y      (o_center_y),
    .o_square_radius (o_square_radius),
    .o_swapped       (o_swapped),
    .o_collinear     (o_collinear),
    .o_saturated     (o_saturated)
);

`default_nettype wire
